// File: design/assert_macros.svh
// assertion macros used by the detector core design file
// no dependencies; include with the bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising edge, masked while reset is asserted
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/bcd_pkg.sv
// types and constants of the button click event detector
// no dependencies; used by the channel interfaces and the core
package bcd_pkg;

    // field widths
    localparam int KEY_W    = 1;
    localparam int TICKS_W  = 8;
    localparam int EVENT_W  = 2;
    localparam int STATE_W  = 3;
    localparam int CFG_W    = 16;
    localparam int EN_W     = 3;
    localparam int CFG_IDX_W = 2;

    // default timer width
    localparam int BCD_TIMER_BITS = 16;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;
    localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;
    localparam logic [EN_W-1:0]  ENABLES_RST  = 3'b111;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLES  = 2'd3;

    // bits of the enable register
    localparam int EN_CLICK  = 0;
    localparam int EN_DOUBLE = 1;
    localparam int EN_LONG   = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE         = 3'd0,
        ST_DEBOUNCE     = 3'd1,
        ST_WAIT_RELEASE = 3'd2,
        ST_WAIT_DOUBLE  = 3'd3,
        ST_LONG_WAIT    = 3'd4
    } t_key_state;

endpackage

// File: design/bcd_in_if.sv
// request channel carrying one key poll
// depends on bcd_pkg
interface bcd_in_if;
    import bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_pressed;
    logic [TICKS_W-1:0] ticks_passed;

    modport source (output valid, key_pressed, ticks_passed, input ready);
    modport sink   (input valid, key_pressed, ticks_passed, output ready);
endinterface

// File: design/bcd_out_if.sv
// result channel carrying the event of one poll and the detector state
// depends on bcd_pkg
interface bcd_out_if;
    import bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [EVENT_W-1:0] prior_event;
    logic [STATE_W-1:0] fsm_state;

    modport source (output valid, event_res, prior_event, fsm_state, input ready);
    modport sink   (input valid, event_res, prior_event, fsm_state, output ready);
endinterface

// File: design/button_click_event_detector_core.sv
// Button click event detector. Each request on i_in is one poll of a
// high-active key plus the ticks that passed since the previous poll.
// Each request gives exactly one result on o_out: the event of that poll
// (none, click, double click, long press), the last reported event and the
// detector state after the poll.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle; the state update (saturating timer
// add, threshold compares, next-state select) is done in the accept
// cycle, and the result register lets the next request in while a result
// is being taken.
// When the receiver stalls, the result stays registered and i_in.ready
// drops until it is taken.
// Reset (i_rst_n low, synchronous) returns to idle with timer, press count
// and last event cleared and registers at 20 / 800 / 300 ticks, all
// events enabled. The user must write registers through i_cfg_we, i_cfg_index
// and i_cfg_wdata only while no request is in flight; the core does not enforce it.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if and assert_macros.svh.
module button_click_event_detector_core #(
    parameter int TIMER_BITS = bcd_pkg::BCD_TIMER_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcd_pkg::CFG_W-1:0]      i_cfg_wdata,
    bcd_in_if.sink                         i_in,
    bcd_out_if.source                      o_out
);
    import bcd_pkg::*;
    `include "assert_macros.svh"

    // compare width covers both timer and thresholds
    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_long;
    logic [CFG_W-1:0] r_double;
    logic [EN_W-1:0]  r_enables;

    // detector state
    t_key_state            r_state,  n_state;
    logic [TIMER_BITS-1:0] r_timer,  n_timer;
    logic [1:0]            r_count,  n_count;
    t_event                r_recent, n_recent;

    // result register
    logic   r_out_valid;
    t_event r_event_res, n_event_res;

    logic                  accept;
    logic [TIMER_BITS:0]   timer_sum;
    logic [TIMER_BITS-1:0] timer_sat;
    logic [CMP_W-1:0]      timer_cmp;
    logic                  reach_debounce;
    logic                  reach_long;
    logic                  reach_double;
    logic                  pressed;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign pressed    = i_in.key_pressed[0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long     <= LONG_RST;
            r_double   <= DOUBLE_RST;
            r_enables  <= ENABLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                CFG_LONG:     r_long     <= i_cfg_wdata;
                CFG_DOUBLE:   r_double   <= i_cfg_wdata;
                CFG_ENABLES:  r_enables  <= i_cfg_wdata[EN_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating timer add and threshold compares
    always_comb begin
        timer_sum      = {1'b0, r_timer} + (TIMER_BITS+1)'(i_in.ticks_passed);
        timer_sat      = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
        timer_cmp      = CMP_W'(timer_sat);
        reach_debounce = timer_cmp >= CMP_W'(r_debounce);
        reach_long     = timer_cmp >= CMP_W'(r_long);
        reach_double   = timer_cmp >= CMP_W'(r_double);
    end

    // next state and event
    always_comb begin
        n_state     = r_state;
        n_timer     = timer_sat;
        n_count     = r_count;
        n_recent    = r_recent;
        n_event_res = EV_NONE;
        case (r_state)
            ST_IDLE: begin
                if (pressed) begin
                    n_state = ST_DEBOUNCE;
                    n_timer = '0;
                end
            end
            ST_DEBOUNCE: begin
                if (reach_debounce) begin
                    n_state = pressed ? ST_WAIT_RELEASE : ST_IDLE;
                    n_timer = '0;
                end
            end
            ST_WAIT_RELEASE: begin
                if (!pressed && !reach_long) begin
                    n_state = ST_WAIT_DOUBLE;
                    n_timer = '0;
                    if (r_count != 2'd3) begin
                        n_count = r_count + 2'd1;
                    end
                end else if (reach_long) begin
                    if (r_enables[EN_LONG]) begin
                        n_event_res = EV_LONG;
                        n_recent    = EV_LONG;
                    end
                    n_state = ST_LONG_WAIT;
                    n_timer = '0;
                end
            end
            ST_WAIT_DOUBLE: begin
                if (r_count == 2'd1) begin
                    if (reach_double) begin
                        if (r_enables[EN_CLICK]) begin
                            n_event_res = EV_CLICK;
                            n_recent    = EV_CLICK;
                        end
                        n_count = '0;
                        n_state = ST_IDLE;
                        n_timer = '0;
                    end else if (pressed) begin
                        n_state = ST_DEBOUNCE;
                        n_timer = '0;
                    end
                end else if (r_count == 2'd2) begin
                    if (r_enables[EN_DOUBLE]) begin
                        n_event_res = EV_DOUBLE;
                        n_recent    = EV_DOUBLE;
                    end
                    n_count = '0;
                    n_state = ST_IDLE;
                    n_timer = '0;
                end else begin
                    // stray count: drop it and start over
                    n_count = '0;
                    n_state = ST_IDLE;
                    n_timer = '0;
                end
            end
            ST_LONG_WAIT: begin
                if (!pressed) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                    n_timer = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_timer = '0;
            end
        endcase
    end

    // state register, updated once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_timer  <= '0;
            r_count  <= '0;
            r_recent <= EV_NONE;
        end else if (accept) begin
            r_state  <= n_state;
            r_timer  <= n_timer;
            r_count  <= n_count;
            r_recent <= n_recent;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event_res <= n_event_res;
        end
    end

    // state and last event are read straight from the state registers:
    // they only change when a new request replaces the result
    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_event_res;
    assign o_out.prior_event = r_recent;
    assign o_out.fsm_state   = r_state;

    // checks
    `ASSERT_CLKED(a_count_bounded, i_clk, i_rst_n, r_count != 2'd3,
        "press count reached three")
    `ASSERT_CLKED(a_event_recorded, i_clk, i_rst_n,
        (r_out_valid && r_event_res != EV_NONE) |-> (r_recent == r_event_res),
        "reported event not recorded as last event")
    `ASSERT_CLKED(a_click_to_idle, i_clk, i_rst_n,
        (r_out_valid && (r_event_res == EV_CLICK || r_event_res == EV_DOUBLE))
            |-> (r_state == ST_IDLE && r_count == 2'd0),
        "click report did not return to idle with cleared count")
    `ASSERT_CLKED(a_long_to_wait, i_clk, i_rst_n,
        (r_out_valid && r_event_res == EV_LONG) |-> (r_state == ST_LONG_WAIT),
        "long press report did not enter long wait release")

endmodule

// File: tb/sv/button_click_event_detector_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the button click event detector core: key polls in,
// one event/state result per poll out, compared against an in-bench detector
// depends on bcd_pkg, bcd_in_if, bcd_out_if and button_click_event_detector_core
module button_click_event_detector_core_tb;
    import bcd_pkg::*;

    localparam int TMR_W = BCD_TIMER_BITS;
    localparam logic [TMR_W:0] TMR_MAX = {1'b0, {TMR_W{1'b1}}};
    localparam int TIMEOUT_NS = 2_000_000;

    typedef struct {
        logic               key;
        logic [TICKS_W-1:0] ticks;
    } t_key_poll;

    typedef struct {
        t_event     ev;
        t_event     last;
        t_key_state st;
    } t_poll_event;

    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_LIGHT    = 2'd1,
        RX_HEAVY    = 2'd2,
        RX_TOGGLE   = 2'd3
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    bcd_in_if  in_ch ();
    bcd_out_if out_ch ();

    button_click_event_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // polls waiting to be sent and events waiting to come back
    t_key_poll   key_polls[$];
    t_poll_event predicted_events[$];
    int          polls_queued = 0;
    int          results_seen = 0;
    int          mismatches = 0;

    // detector shadow: registers and state
    logic [CFG_W-1:0] cfg_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0] cfg_long     = LONG_RST;
    logic [CFG_W-1:0] cfg_double   = DOUBLE_RST;
    logic [EN_W-1:0]  cfg_enables  = ENABLES_RST;
    t_key_state       key_fsm      = ST_IDLE;
    logic [TMR_W-1:0] key_timer    = '0;
    logic [1:0]       press_cnt    = '0;
    t_event           recent_ev    = EV_NONE;

    // sender burst and receiver stall state
    int       burst_left = 6;
    int       gap_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 40;
    int       rx_hold_left = 0;
    bit       rx_hold_done = 0;
    logic     rx_ready_next;
    t_poll_event want;

    // clock and reset
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // timer is cleared on every state change
    function automatic void move_to(input t_key_state nxt);
        key_fsm = nxt;
        key_timer = '0;
    endfunction

    // one poll through the detector, returns the event/state it should report
    function automatic t_poll_event advance_detector(input logic key,
                                                     input logic [TICKS_W-1:0] ticks);
        logic [TMR_W:0]   sum;
        logic [TMR_W-1:0] t;
        t_poll_event      r;
        r.ev = EV_NONE;
        sum = {1'b0, key_timer} + (TMR_W+1)'(ticks);
        key_timer = (sum > TMR_MAX) ? TMR_MAX[TMR_W-1:0] : sum[TMR_W-1:0];
        t = key_timer;
        case (key_fsm)
            ST_IDLE: begin
                if (key) move_to(ST_DEBOUNCE);
            end
            ST_DEBOUNCE: begin
                if (t >= cfg_debounce) move_to(key ? ST_WAIT_RELEASE : ST_IDLE);
            end
            ST_WAIT_RELEASE: begin
                if (!key && t < cfg_long) begin
                    move_to(ST_WAIT_DOUBLE);
                    if (press_cnt != 2'd3) press_cnt = press_cnt + 2'd1;
                end else if (t >= cfg_long) begin
                    if (cfg_enables[EN_LONG]) begin
                        r.ev = EV_LONG;
                        recent_ev = EV_LONG;
                    end
                    move_to(ST_LONG_WAIT);
                end
            end
            ST_WAIT_DOUBLE: begin
                if (press_cnt == 2'd1) begin
                    if (t >= cfg_double) begin
                        if (cfg_enables[EN_CLICK]) begin
                            r.ev = EV_CLICK;
                            recent_ev = EV_CLICK;
                        end
                        press_cnt = '0;
                        move_to(ST_IDLE);
                    end else if (key) begin
                        move_to(ST_DEBOUNCE);
                    end
                end else if (press_cnt == 2'd2) begin
                    if (cfg_enables[EN_DOUBLE]) begin
                        r.ev = EV_DOUBLE;
                        recent_ev = EV_DOUBLE;
                    end
                    press_cnt = '0;
                    move_to(ST_IDLE);
                end else begin
                    press_cnt = '0;
                    move_to(ST_IDLE);
                end
            end
            ST_LONG_WAIT: begin
                if (!key) begin
                    move_to(ST_IDLE);
                    press_cnt = '0;
                end
            end
            default: move_to(ST_IDLE);
        endcase
        r.last = recent_ev;
        r.st = key_fsm;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
        mismatches++;
        if (mismatches <= 60)
            $display("mismatch on result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, exp_val);
    endtask

    // request driver: bursts of polls with random gaps, request held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_events.push_back(advance_detector(in_ch.key_pressed,
                                                            in_ch.ticks_passed));
                void'(key_polls.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (in_ch.valid && !in_ch.ready) begin
                // request stays on the bus until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (key_polls.size() > 0) begin
                in_ch.valid        <= 1'b1;
                in_ch.key_pressed  <= key_polls[0].key;
                in_ch.ticks_passed <= key_polls[0].ticks;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (predicted_events.size() == 0) begin
                    flag_mismatch("result with nothing pending, event_res",
                                  out_ch.event_res, EV_NONE);
                end else begin
                    want = predicted_events.pop_front();
                    if (out_ch.event_res !== want.ev)
                        flag_mismatch("event_res", out_ch.event_res, want.ev);
                    if (out_ch.prior_event !== want.last)
                        flag_mismatch("prior_event", out_ch.prior_event, want.last);
                    if (out_ch.fsm_state !== want.st)
                        flag_mismatch("fsm_state", out_ch.fsm_state, want.st);
                end
            end

            // switch stall pattern now and then
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 96);
            end else begin
                rx_mode_left--;
            end

            // one long hold-off while the sender still has plenty queued
            if (!rx_hold_done && results_seen >= 200 && key_polls.size() > 40) begin
                rx_hold_left = 120;
                rx_hold_done = 1;
            end

            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_ready_next = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rx_ready_next = 1'b1;
                    RX_LIGHT:  rx_ready_next = ($urandom_range(0, 3) != 0);
                    RX_HEAVY:  rx_ready_next = ($urandom_range(0, 3) == 0);
                    default:   rx_ready_next = rx_mode_left[0];
                endcase
            end
            out_ch.ready <= rx_ready_next;
        end
    end

    task automatic push_poll(input int key, input int ticks);
        t_key_poll p;
        p.key = key[0];
        p.ticks = ticks[TICKS_W-1:0];
        key_polls.push_back(p);
        polls_queued++;
    endtask

    // hold one key level for about span ticks, split over random polls
    task automatic push_span(input logic key, input int span);
        int left;
        int coarse;
        int step;
        left = span;
        coarse = span / 3;
        if (coarse < 1) coarse = 1;
        if (coarse > 255) coarse = 255;
        do begin
            step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, coarse);
            push_poll(int'(key), step);
            left -= step;
        end while (left > 0);
    endtask

    // one key gesture shaped around the current thresholds
    task automatic push_gesture();
        int deb;
        int lng;
        int dbl;
        int n;
        deb = cfg_debounce;
        lng = cfg_long;
        dbl = cfg_double;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // single click
                push_span(1'b1, deb + $urandom_range(0, lng / 2 + 1));
                push_span(1'b0, dbl + $urandom_range(0, 40));
            end
            3, 4: begin
                // double click
                push_span(1'b1, deb + $urandom_range(0, lng / 2 + 1));
                push_span(1'b0, $urandom_range(0, dbl));
                push_span(1'b1, deb + $urandom_range(0, lng / 2 + 1));
                push_span(1'b0, dbl + $urandom_range(0, 40));
            end
            5: begin
                // long press
                push_span(1'b1, deb + lng + $urandom_range(0, 300));
                push_span(1'b0, $urandom_range(0, 60));
            end
            6: begin
                // press too short to get past debounce
                push_span(1'b1, $urandom_range(0, deb));
                push_span(1'b0, deb + $urandom_range(0, 30));
            end
            7: begin
                // stale count: click, bounced second press, then a clean click
                push_span(1'b1, deb + $urandom_range(0, lng / 2 + 1));
                push_span(1'b0, $urandom_range(0, dbl));
                push_span(1'b1, $urandom_range(0, deb));
                push_span(1'b0, deb + $urandom_range(0, 10));
                push_span(1'b1, deb + $urandom_range(0, lng / 2 + 1));
                push_span(1'b0, dbl + $urandom_range(0, 40));
            end
            default: begin
                // noise
                n = $urandom_range(1, 8);
                repeat (n) push_poll($urandom_range(0, 1), $urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic push_random_polls(input int count);
        int start;
        start = polls_queued;
        while (polls_queued - start < count) push_gesture();
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (key_polls.size() != 0 || predicted_events.size() != 0 || in_ch.valid);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: cfg_debounce = data;
            CFG_LONG:     cfg_long = data;
            CFG_DOUBLE:   cfg_double = data;
            default:      cfg_enables = data[EN_W-1:0];
        endcase
    endtask

    task automatic set_thresholds(input int deb, input int lng, input int dbl, input int en);
        write_reg(CFG_DEBOUNCE, deb[CFG_W-1:0]);
        write_reg(CFG_LONG, lng[CFG_W-1:0]);
        write_reg(CFG_DOUBLE, dbl[CFG_W-1:0]);
        write_reg(CFG_ENABLES, en[CFG_W-1:0]);
    endtask

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus sequence
    initial begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.key_pressed = '0;
        in_ch.ticks_passed = '0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // reset thresholds 20 / 800 / 300, all events on
        push_poll(0, 0);
        push_poll(0, 255);
        // single click
        push_poll(1, 0);
        push_poll(1, 19);
        push_poll(1, 1);
        push_poll(0, 5);
        push_poll(0, 255);
        push_poll(0, 45);
        // double click
        push_poll(1, 7);
        push_poll(1, 20);
        push_poll(0, 3);
        push_poll(1, 2);
        push_poll(1, 200);
        push_poll(0, 0);
        push_poll(0, 0);
        // long press, hold, release
        push_poll(1, 0);
        push_poll(1, 255);
        push_poll(1, 255);
        push_poll(1, 255);
        push_poll(1, 255);
        push_poll(1, 35);
        push_poll(1, 9);
        push_poll(0, 0);
        // bounced second press leaves the count, next click makes a double
        push_poll(1, 0);
        push_poll(1, 20);
        push_poll(0, 1);
        push_poll(1, 1);
        push_poll(0, 20);
        push_poll(1, 0);
        push_poll(1, 20);
        push_poll(0, 0);
        push_poll(0, 0);
        push_random_polls(200);
        wait_drained();

        // all thresholds zero, every event disabled
        set_thresholds(0, 0, 0, 0);
        @(negedge i_clk);
        push_random_polls(150);
        wait_drained();

        // top thresholds: the timer has to saturate to move on
        set_thresholds(65535, 65535, 65535, 7);
        @(negedge i_clk);
        push_poll(1, 0);
        repeat (258) push_poll(1, 255);
        repeat (258) push_poll(1, 255);
        push_poll(1, 255);
        push_poll(0, 255);
        wait_drained();

        // random thresholds and enable masks
        repeat (4) begin
            set_thresholds($urandom_range(0, 40), $urandom_range(0, 600),
                           $urandom_range(0, 300), $urandom_range(0, 7));
            @(negedge i_clk);
            push_random_polls(100);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
